// File: hdl/uer_pkg.sv
package uer_pkg;

    // Sequencer phases of one ping
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT
    } phase_t;

    // Held result status codes
    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_PING_INTERVAL = 2'd0;
    localparam logic [1:0] REG_ECHO_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_TRIGGER_WIDTH = 2'd2;

    // Register reset values
    localparam logic [19:0] PING_INTERVAL_RST = 20'd75000;
    localparam logic [15:0] ECHO_TIMEOUT_RST  = 16'd30000;
    localparam logic [7:0]  TRIGGER_WIDTH_RST = 8'd10;

    // Counter ceilings
    localparam logic [19:0] MAX20 = 20'hFFFFF;
    localparam logic [15:0] MAX16 = 16'hFFFF;

    // Division by 29 through a reciprocal: floor(w/29) = (w*72316) >> 21 for w < 2^16
    localparam logic [32:0] DIV29_RECIP = 33'd72316;
    localparam int          DIV29_SHIFT = 21;

    // floor((50*lo + 14) / 29) for the remainder lo of a division by 29
    localparam logic [5:0] FRAC_TBL [0:31] = '{
        6'd0,  6'd2,  6'd3,  6'd5,  6'd7,  6'd9,  6'd10, 6'd12,
        6'd14, 6'd16, 6'd17, 6'd19, 6'd21, 6'd22, 6'd24, 6'd26,
        6'd28, 6'd29, 6'd31, 6'd33, 6'd34, 6'd36, 6'd38, 6'd40,
        6'd41, 6'd43, 6'd45, 6'd47, 6'd48, 6'd0,  6'd0,  6'd0
    };

    // Word passed from the tick sequencer to the distance converter
    typedef struct packed {
        logic        trig;
        logic        ready;
        logic [1:0]  status;
        logic [15:0] width;
    } tick_word_t;

endpackage

// File: hdl/ultrasonic_echo_ranger.sv
// Echo ranger for a trigger/echo ultrasonic sensor.
// The input channel (in_valid, in_stall, echo_level) takes one word per
// microsecond tick, holding the sampled echo line. For every input word the
// output channel (out_valid, out_stall) delivers one word: the trigger level
// for that tick, a one-tick result_ready flag, and the held range_status and
// distance_centi_cm, the latter being round(width*100/58).
// The path from acceptance to the output register is the sequencer stage
// followed by a two-stage distance converter (reciprocal multiply, then
// remainder table). One word is accepted per cycle while the receiver does
// not hold the stages full.
// When the receiver stalls, the stages fill up and in_stall rises once all
// three hold a word; nothing is dropped.
// At reset the registers return to 75000, 30000 and 10 microseconds, the
// sequencer is idle with all counters at zero, and the held status reads
// "none yet" with a distance of zero. The APB-style port at byte addresses
// 0, 4 and 8 writes and reads the ping interval, echo timeout and trigger
// width; the user must change configuration only while idle; not enforced.
module ultrasonic_echo_ranger
    import uer_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         echo_level,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         trigger_level,
    output logic         result_ready,
    output logic [1:0]   range_status,
    output logic [16:0]  distance_centi_cm
);

    logic [19:0] ping_interval_reg;
    logic [15:0] echo_timeout_reg;
    logic [7:0]  trigger_width_reg;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [19:0] interval_count_reg;
    logic [19:0] interval_count_next;
    logic [15:0] since_ping_reg;
    logic [15:0] since_ping_next;
    logic        rise_seen_reg;
    logic        rise_seen_next;
    logic [15:0] pulse_width_reg;
    logic [15:0] pulse_width_next;
    logic        prev_echo_reg;
    logic [1:0]  held_status_reg;
    logic [1:0]  held_status_next;
    logic [15:0] held_width_reg;
    logic [15:0] held_width_next;

    logic        s1_valid_reg;
    tick_word_t  s1_word_reg;
    tick_word_t  s1_word_next;

    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    logic        in_fire;
    logic        load_s1;
    logic        conv_stall;
    logic        rise;
    logic        fall;
    logic        start_ping;
    logic        timeout;
    logic        finish;
    logic [19:0] interval_inc;
    logic [15:0] since_inc;
    logic [7:0]  trig_width_eff;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        case (cfg_idx)
            REG_PING_INTERVAL: prdata = {12'b0, ping_interval_reg};
            REG_ECHO_TIMEOUT:  prdata = {16'b0, echo_timeout_reg};
            REG_TRIGGER_WIDTH: prdata = {24'b0, trigger_width_reg};
            default:           prdata = 32'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ping_interval_reg <= PING_INTERVAL_RST;
            echo_timeout_reg  <= ECHO_TIMEOUT_RST;
            trigger_width_reg <= TRIGGER_WIDTH_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_PING_INTERVAL: ping_interval_reg <= pwdata[19:0];
                REG_ECHO_TIMEOUT:  echo_timeout_reg  <= pwdata[15:0];
                REG_TRIGGER_WIDTH: trigger_width_reg <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    // Input handshake: the sequencer stage moves on when it is empty or drains
    assign load_s1  = !s1_valid_reg || !conv_stall;
    assign in_stall = !load_s1;
    assign in_fire  = in_valid && !in_stall;

    // Edge detection and counter increments
    assign rise           = echo_level && !prev_echo_reg;
    assign fall           = !echo_level && prev_echo_reg;
    assign interval_inc   = (interval_count_reg == MAX20) ? interval_count_reg
                                                          : interval_count_reg + 20'd1;
    assign since_inc      = (since_ping_reg == MAX16) ? since_ping_reg
                                                      : since_ping_reg + 16'd1;
    assign trig_width_eff = (trigger_width_reg == 8'd0) ? 8'd1 : trigger_width_reg;
    assign start_ping     = (phase_reg == PH_IDLE) && (interval_count_reg >= ping_interval_reg);
    assign timeout        = since_inc >= echo_timeout_reg;
    assign finish         = (phase_reg != PH_IDLE) && (fall || timeout);

    // Next phase
    always_comb
    begin
        case (phase_reg)
            PH_IDLE:
            begin
                phase_next = start_ping ? PH_TRIG : PH_IDLE;
            end
            PH_TRIG, PH_WAIT:
            begin
                if (finish)
                begin
                    phase_next = PH_IDLE;
                end
                else if (since_inc < {8'b0, trig_width_eff})
                begin
                    phase_next = PH_TRIG;
                end
                else
                begin
                    phase_next = PH_WAIT;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Counters, pulse timing and the held result
    always_comb
    begin
        interval_count_next = interval_count_reg;
        since_ping_next     = since_ping_reg;
        rise_seen_next      = rise_seen_reg;
        pulse_width_next    = pulse_width_reg;
        held_status_next    = held_status_reg;
        held_width_next     = held_width_reg;
        s1_word_next.trig   = 1'b0;
        s1_word_next.ready  = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start_ping)
                begin
                    interval_count_next = 20'd1;
                    since_ping_next     = 16'd0;
                    rise_seen_next      = 1'b0;
                    pulse_width_next    = 16'd0;
                    s1_word_next.trig   = 1'b1;
                end
                else
                begin
                    interval_count_next = interval_inc;
                end
            end
            PH_TRIG, PH_WAIT:
            begin
                interval_count_next = interval_inc;
                since_ping_next     = since_inc;
                s1_word_next.trig   = since_inc < {8'b0, trig_width_eff};
                if (rise)
                begin
                    rise_seen_next   = 1'b1;
                    pulse_width_next = 16'd1;
                end
                else if (echo_level && rise_seen_reg && (pulse_width_reg != MAX16))
                begin
                    pulse_width_next = pulse_width_reg + 16'd1;
                end
                if (fall)
                begin
                    if (rise_seen_reg && (pulse_width_reg != 16'd0))
                    begin
                        held_status_next = ST_VALID;
                        held_width_next  = pulse_width_reg;
                    end
                    else
                    begin
                        held_status_next = ST_INVALID;
                        held_width_next  = 16'd0;
                    end
                end
                else if (timeout)
                begin
                    held_status_next = ST_TIMEOUT;
                    held_width_next  = 16'd0;
                end
                if (finish)
                begin
                    s1_word_next.ready = 1'b1;
                    s1_word_next.trig  = 1'b0;
                end
            end
            default:
            begin
                interval_count_next = interval_inc;
            end
        endcase
        s1_word_next.status = held_status_next;
        s1_word_next.width  = held_width_next;
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            interval_count_reg <= 20'd0;
            since_ping_reg     <= 16'd0;
            rise_seen_reg      <= 1'b0;
            pulse_width_reg    <= 16'd0;
            prev_echo_reg      <= 1'b0;
            held_status_reg    <= ST_NONE;
            held_width_reg     <= 16'd0;
        end
        else if (in_fire)
        begin
            phase_reg          <= phase_next;
            interval_count_reg <= interval_count_next;
            since_ping_reg     <= since_ping_next;
            rise_seen_reg      <= rise_seen_next;
            pulse_width_reg    <= pulse_width_next;
            prev_echo_reg      <= echo_level;
            held_status_reg    <= held_status_next;
            held_width_reg     <= held_width_next;
        end
    end

    // Sequencer output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (load_s1)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_word_reg <= s1_word_next;
        end
    end

    // Distance conversion and output register
    uer_range_conv u_conv (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (s1_valid_reg),
        .in_stall          (conv_stall),
        .in_word           (s1_word_reg),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .trigger_level     (trigger_level),
        .result_ready      (result_ready),
        .range_status      (range_status),
        .distance_centi_cm (distance_centi_cm)
    );

    // A completed ping always leaves the sequencer idle.
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && finish) |=> (phase_reg == PH_IDLE))
        else $error("sequencer not idle after completion");

    // The trigger is never driven on the tick a result completes.
    a_trig_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(trigger_level && result_ready))
        else $error("trigger and result on the same tick");

    // A completed result never reports the no-measurement status.
    a_ready_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_ready) |-> (range_status != ST_NONE))
        else $error("result without a status");

    // The distance is zero unless the status is a valid measurement.
    a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (range_status != ST_VALID)) |-> (distance_centi_cm == 17'd0))
        else $error("distance held without a valid measurement");

endmodule

// File: hdl/uer_range_conv.sv
module uer_range_conv
    import uer_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  tick_word_t       in_word,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             trigger_level,
    output logic             result_ready,
    output logic [1:0]       range_status,
    output logic [16:0]      distance_centi_cm
);

    logic        a_valid_reg;
    tick_word_t  a_word_reg;
    logic [11:0] a_hi_reg;
    logic        b_valid_reg;
    logic        b_trig_reg;
    logic        b_ready_reg;
    logic [1:0]  b_status_reg;
    logic [16:0] b_dist_reg;

    logic        load_a;
    logic        load_b;
    logic [32:0] product;
    logic [15:0] hi_times;
    logic [15:0] rem_full;
    logic [4:0]  rem_lo;
    logic [16:0] dist_next;

    // Elastic stage control
    assign load_b   = !b_valid_reg || !out_stall;
    assign load_a   = !a_valid_reg || load_b;
    assign in_stall = !load_a;

    // First stage: quotient by 29 through the reciprocal
    assign product = {17'b0, in_word.width} * DIV29_RECIP;

    // Second stage: remainder, table lookup and recombination
    assign hi_times  = {4'b0, a_hi_reg} * 16'd29;
    assign rem_full  = a_word_reg.width - hi_times;
    assign rem_lo    = rem_full[4:0];
    assign dist_next = {5'b0, a_hi_reg} * 17'd50 + {11'b0, FRAC_TBL[rem_lo]};

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (load_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load_a && in_valid)
        begin
            a_word_reg <= in_word;
            a_hi_reg   <= product[32:DIV29_SHIFT];
        end
        if (load_b && a_valid_reg)
        begin
            b_trig_reg   <= a_word_reg.trig;
            b_ready_reg  <= a_word_reg.ready;
            b_status_reg <= a_word_reg.status;
            b_dist_reg   <= dist_next;
        end
    end

    assign out_valid         = b_valid_reg;
    assign trigger_level     = b_trig_reg;
    assign result_ready      = b_ready_reg;
    assign range_status      = b_status_reg;
    assign distance_centi_cm = b_dist_reg;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import uer_pkg::*;

    // Address slot beyond the last register; writes there must be ignored.
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 1300;
    localparam int SETTLE_TICKS = 8;

    typedef struct packed {
        logic        trig;
        logic        ready;
        logic [1:0]  status;
        logic [16:0] distance;
    } range_word_t;

    typedef enum logic {
        ROW_TICK,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  idx;
        logic [31:0] value;
        logic        echo;
        logic        typed;
        range_word_t word;
    } stim_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        echo_level = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        trigger_level;
    logic        result_ready;
    logic [1:0]  range_status;
    logic [16:0] distance_centi_cm;

    // Register copies kept alongside the block.
    logic [19:0] cfg_interval = PING_INTERVAL_RST;
    logic [15:0] cfg_timeout = ECHO_TIMEOUT_RST;
    logic [7:0]  cfg_trig_w = TRIGGER_WIDTH_RST;

    // Ranger state as it should be after every accepted word.
    phase_t      seq_phase = PH_IDLE;
    logic [19:0] interval_cnt = '0;
    logic [15:0] since_cnt = '0;
    logic        rise_seen = 1'b0;
    logic [15:0] pulse_len = '0;
    logic        prev_echo = 1'b0;
    logic [16:0] held_dist = '0;
    logic [1:0]  held_st = ST_NONE;
    logic        ping_began = 1'b0;

    range_word_t pending_range_words[$];
    logic        echo_plan[$];
    logic        idle_line = 1'b0;
    int          tx_gap_pct = 11;
    int          rx_stall_pct = 45;
    int          mismatches = 0;
    int          random_items = 0;

    ultrasonic_echo_ranger u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .echo_level        (echo_level),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .trigger_level     (trigger_level),
        .result_ready      (result_ready),
        .range_status      (range_status),
        .distance_centi_cm (distance_centi_cm)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the ranger by one microsecond tick and return the word it should emit.
    function automatic range_word_t next_range_word(input logic echo);
        range_word_t w;
        logic        rise;
        logic        fall;
        logic [7:0]  trig_len;
        rise       = echo && !prev_echo;
        fall       = !echo && prev_echo;
        trig_len   = (cfg_trig_w == 8'd0) ? 8'd1 : cfg_trig_w;
        w          = '0;
        ping_began = 1'b0;
        if (seq_phase == PH_IDLE)
        begin
            if (interval_cnt >= cfg_interval)
            begin
                seq_phase    = PH_TRIG;
                interval_cnt = 20'd1;
                since_cnt    = 16'd0;
                rise_seen    = 1'b0;
                pulse_len    = 16'd0;
                w.trig       = 1'b1;
                ping_began   = 1'b1;
            end
            else if (interval_cnt != MAX20)
                interval_cnt = interval_cnt + 20'd1;
        end
        else
        begin
            if (interval_cnt != MAX20)
                interval_cnt = interval_cnt + 20'd1;
            if (since_cnt != MAX16)
                since_cnt = since_cnt + 16'd1;
            if (since_cnt < {8'd0, trig_len})
            begin
                seq_phase = PH_TRIG;
                w.trig    = 1'b1;
            end
            else
                seq_phase = PH_WAIT;

            if (rise)
            begin
                rise_seen = 1'b1;
                pulse_len = 16'd1;
            end
            else if (echo && rise_seen && pulse_len != MAX16)
                pulse_len = pulse_len + 16'd1;

            // A falling edge takes priority over a timeout on the same tick.
            if (fall || since_cnt >= cfg_timeout)
            begin
                if (!fall)
                begin
                    held_st   = ST_TIMEOUT;
                    held_dist = '0;
                end
                else if (rise_seen && pulse_len != 16'd0)
                begin
                    held_st   = ST_VALID;
                    held_dist = 17'((32'(pulse_len) * 32'd100 + 32'd29) / 32'd58);
                end
                else
                begin
                    held_st   = ST_INVALID;
                    held_dist = '0;
                end
                seq_phase = PH_IDLE;
                w.ready   = 1'b1;
                w.trig    = 1'b0;
            end
        end
        prev_echo  = echo;
        w.status   = held_st;
        w.distance = held_dist;
        return w;
    endfunction

    function automatic stim_row_t tick_row(input logic echo, input logic typed,
                                           input range_word_t word);
        stim_row_t r;
        r       = '0;
        r.kind  = ROW_TICK;
        r.echo  = echo;
        r.typed = typed;
        r.word  = word;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [31:0] value);
        stim_row_t r;
        r       = '0;
        r.kind  = ROW_REG;
        r.idx   = idx;
        r.value = value;
        return r;
    endfunction

    // Occasionally set bits above the register width; the block must drop them.
    function automatic logic [31:0] with_junk(input logic [31:0] value, input int bits);
        return value | (($urandom_range(3) == 0) ? ($urandom << bits) : 32'd0);
    endfunction

    // Echo line for the next tick: the planned echo shape first, then line noise while idle, else low.
    function automatic logic next_echo();
        if (echo_plan.size() != 0)
            return echo_plan.pop_front();
        if (seq_phase != PH_IDLE)
            return 1'b0;
        if (idle_line)
            idle_line = ($urandom_range(2) != 0);
        else
            idle_line = ($urandom_range(14) == 0);
        return idle_line;
    endfunction

    // Shape the echo seen after a ping start, mostly as a real sensor would answer.
    function automatic void plan_echo();
        int kind;
        int lag;
        int high_len;
        int room;
        int trig_len;
        echo_plan.delete();
        trig_len = (cfg_trig_w == 8'd0) ? 1 : int'(cfg_trig_w);
        kind     = $urandom_range(99);
        // With a long timeout only shapes that end in a fall keep the run short.
        if (cfg_timeout > 16'd3000)
            kind = 0;
        lag      = 0;
        high_len = 0;
        if (kind < 70)
        begin
            lag  = $urandom_range(0, trig_len + 8);
            room = $urandom_range(99);
            if (room < 85)
                high_len = $urandom_range(1, 40);
            else if (room < 95)
                high_len = $urandom_range(41, 400);
            else
                high_len = $urandom_range(401, 1000);
            room = int'(cfg_timeout) - 1 - lag;
            if (room >= 1 && high_len > room)
                high_len = room;
        end
        else if (kind < 80)
        begin
            repeat ($urandom_range(1, 30)) echo_plan.push_back(1'($urandom_range(1)));
            return;
        end
        else if (kind < 90)
            return;
        else if (kind < 95)
        begin
            // The echo rises only after the ping has already timed out.
            lag      = int'(cfg_timeout) + $urandom_range(0, 3);
            high_len = $urandom_range(1, 5);
        end
        else
            // The fall lands on the very tick the timeout expires.
            high_len = int'(cfg_timeout) - 1;
        if (high_len < 1)
            return;
        repeat (lag) echo_plan.push_back(1'b0);
        repeat (high_len) echo_plan.push_back(1'b1);
        echo_plan.push_back(1'b0);
    endfunction

    // Offer one input word, with random gaps, and record what it should produce.
    task automatic send_tick(input logic echo, input logic typed, input range_word_t word);
        range_word_t w;
        while ($urandom_range(99) < tx_gap_pct)
        begin
            in_valid   <= 1'b0;
            echo_level <= 1'($urandom_range(1));
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        echo_level <= echo;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        w = next_range_word(echo);
        pending_range_words.push_back(typed ? word : w);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_range_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Register write followed by a read back of the same register.
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] masked;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_PING_INTERVAL:
            begin
                cfg_interval = value[19:0];
                masked       = {12'd0, value[19:0]};
            end
            REG_ECHO_TIMEOUT:
            begin
                cfg_timeout = value[15:0];
                masked      = {16'd0, value[15:0]};
            end
            REG_TRIGGER_WIDTH:
            begin
                cfg_trig_w = value[7:0];
                masked     = {24'd0, value[7:0]};
            end
            default:
                masked = '0;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx != REG_UNUSED && prdata !== masked)
        begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: register %0d read back %h, expected %h",
                         $realtime, idx, prdata, masked);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Idling follows the progress of the random part.
    task automatic random_tick();
        send_tick(next_echo(), 1'b0, '0);
        random_items++;
        if (ping_began)
            plan_echo();
        if (random_items < RANDOM_ITEMS / 3)
        begin
            tx_gap_pct   = 11;
            rx_stall_pct = 45;
        end
        else if (random_items < 2 * RANDOM_ITEMS / 3)
        begin
            tx_gap_pct   = 45;
            rx_stall_pct = 11;
        end
        else
        begin
            tx_gap_pct   = 0;
            rx_stall_pct = 0;
        end
    endtask

    // Compare every accepted output word with the oldest pending one.
    always @(posedge clk)
    begin : word_monitor
        range_word_t seen;
        range_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = {trigger_level, result_ready, range_status, distance_centi_cm};
            if (pending_range_words.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected word trig=%0d ready=%0d status=%0d dist=%0d",
                             $realtime, seen.trig, seen.ready, seen.status, seen.distance);
                mismatches++;
            end
            else
            begin
                want = pending_range_words.pop_front();
                if (seen.trig !== want.trig || seen.ready !== want.ready ||
                    seen.status !== want.status || seen.distance !== want.distance)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display({"%0t: expected trig=%0d ready=%0d status=%0d dist=%0d, ",
                                  "got trig=%0d ready=%0d status=%0d dist=%0d"},
                                 $realtime, want.trig, want.ready, want.status,
                                 want.distance, seen.trig, seen.ready, seen.status,
                                 seen.distance);
                    mismatches++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t   rows[$];
        int          phase_no;
        int          phase_len;
        logic [31:0] iv;
        logic [31:0] to;
        logic [31:0] tw;

        // Directed ticks: reset state, zero settings, edge cases of one ping.
        rows.push_back(tick_row(1'b0, 1'b1, {1'b0, 1'b0, ST_NONE, 17'd0}));
        rows.push_back(tick_row(1'b1, 1'b1, {1'b0, 1'b0, ST_NONE, 17'd0}));
        rows.push_back(tick_row(1'b0, 1'b1, {1'b0, 1'b0, ST_NONE, 17'd0}));
        rows.push_back(reg_row(REG_PING_INTERVAL, 32'd0));
        rows.push_back(reg_row(REG_ECHO_TIMEOUT, 32'd0));
        rows.push_back(reg_row(REG_TRIGGER_WIDTH, 32'd0));
        // Zero interval pings at once; zero timeout gives up on the next tick.
        rows.push_back(tick_row(1'b0, 1'b1, {1'b1, 1'b0, ST_NONE, 17'd0}));
        rows.push_back(tick_row(1'b0, 1'b1, {1'b0, 1'b1, ST_TIMEOUT, 17'd0}));
        rows.push_back(reg_row(REG_ECHO_TIMEOUT, 32'd4));
        rows.push_back(reg_row(REG_TRIGGER_WIDTH, 32'd2));
        // Line already high at ping start, so its fall has no rise before it.
        rows.push_back(tick_row(1'b1, 1'b1, {1'b1, 1'b0, ST_TIMEOUT, 17'd0}));
        rows.push_back(tick_row(1'b1, 1'b1, {1'b1, 1'b0, ST_TIMEOUT, 17'd0}));
        rows.push_back(tick_row(1'b0, 1'b1, {1'b0, 1'b1, ST_INVALID, 17'd0}));
        // Rise during the trigger, fall on the same tick as the timeout.
        rows.push_back(tick_row(1'b0, 1'b1, {1'b1, 1'b0, ST_INVALID, 17'd0}));
        rows.push_back(tick_row(1'b1, 1'b1, {1'b1, 1'b0, ST_INVALID, 17'd0}));
        rows.push_back(tick_row(1'b1, 1'b0, '0));
        rows.push_back(tick_row(1'b1, 1'b0, '0));
        rows.push_back(tick_row(1'b0, 1'b1, {1'b0, 1'b1, ST_VALID, 17'd5}));
        // Zero trigger width still gives a single trigger tick.
        rows.push_back(reg_row(REG_TRIGGER_WIDTH, 32'd0));
        rows.push_back(tick_row(1'b0, 1'b1, {1'b1, 1'b0, ST_VALID, 17'd5}));
        rows.push_back(tick_row(1'b0, 1'b1, {1'b0, 1'b0, ST_VALID, 17'd5}));
        rows.push_back(tick_row(1'b0, 1'b0, '0));
        rows.push_back(tick_row(1'b0, 1'b0, '0));
        rows.push_back(tick_row(1'b0, 1'b1, {1'b0, 1'b1, ST_TIMEOUT, 17'd0}));
        rows.push_back(reg_row(REG_UNUSED, 32'h0000_1234));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_REG)
            begin
                wait_drained();
                reg_write(rows[i].idx, rows[i].value);
            end
            else
                send_tick(rows[i].echo, rows[i].typed, rows[i].word);
        end

        // Random part: a run of settings, each followed by a stretch of ticks.
        phase_no = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            // Let the ping in flight finish before touching the registers.
            while (seq_phase != PH_IDLE)
                random_tick();
            wait_drained();
            case (phase_no)
                0:
                begin
                    iv = 32'd0;
                    to = 32'd60;
                    tw = 32'd10;
                end
                1:
                begin
                    iv = 32'd1000;
                    to = 32'd100;
                    tw = 32'd1;
                end
                2:
                begin
                    iv = '1;
                    to = '1;
                    tw = '1;
                end
                3:
                begin
                    iv = 32'd0;
                    to = 32'd65535;
                    tw = 32'd255;
                end
                default:
                begin
                    iv = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(1, 150);
                    to = ($urandom_range(9) == 0) ? $urandom_range(0, 3)
                                                  : $urandom_range(20, 400);
                    tw = ($urandom_range(19) == 0) ? 32'd255 : $urandom_range(0, 20);
                    iv = with_junk(iv, 20);
                    to = with_junk(to, 16);
                    tw = with_junk(tw, 8);
                end
            endcase
            reg_write(REG_PING_INTERVAL, iv);
            reg_write(REG_ECHO_TIMEOUT, to);
            reg_write(REG_TRIGGER_WIDTH, tw);
            echo_plan.delete();
            phase_len = (phase_no == 2) ? 60 : $urandom_range(80, 140);
            for (int k = 0; k < phase_len; k++)
            begin
                // Once, hold the sender back until every word has come out.
                if (phase_no == 5 && k == phase_len / 2)
                    wait_drained();
                random_tick();
            end
            phase_no++;
        end
        wait_drained();

        if (mismatches == 0 && pending_range_words.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
